FILE: rtl/core/fmcr_pkg.sv
package fmcr_pkg;

  // Motor count and the fixed number of result slots on the ports.
  localparam int MOTOR_COUNT_DEFAULT = 5;
  localparam int MAX_MOTORS          = 5;

  // Field widths.
  localparam int WIDTH_W   = 12;
  localparam int TIMEOUT_W = 16;
  localparam int IDLE_W    = 17;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;
  localparam int WORD_W    = 32;

  // Register map of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 1'd1;

  // Register reset values.
  localparam logic [WIDTH_W-1:0]   FULL_SCALE_RESET = 12'd2000;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET    = 16'd1000;

  // Operation codes on the input channel.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Cause codes on the result channel.
  localparam logic CAUSE_FRAME = 1'b0;
  localparam logic CAUSE_STOP  = 1'b1;

  // Pending result from the parser to the conversion stage.
  typedef struct packed {
    logic valid;
    logic cause;
  } ev_ctrl_t;

endpackage

FILE: rtl/core/framed_motor_command_receiver.sv
// Framed motor command receiver. Each input transaction is either a received
// serial byte or a one millisecond tick. A frame is 's','t', four little-endian
// single-precision bytes per motor, then 'e','n'; a wrong marker byte drops the
// partial frame (an 's' in its place starts a new header). A complete frame
// gives one result with cause 0: each command is clamped to [-1,1], the width
// is the truncated product of its magnitude and full_scale_width, and the
// direction is set for strictly positive commands; NaN gives width 0. A tick
// after a frame clears the frame mark and the tick count; otherwise it
// counts, and once the count passes timeout_ticks a stop result with cause 1
// and all zeros is sent. The block takes one transaction per clock cycle while
// item stall is low. A transaction that completes a result is registered in
// the parser's event register, which holds the command words, and then passes
// through the parallel multiply-and-shift converters into the output register.
// Item stall rises only when both the event register and the output register
// hold results and the output is stalled. The configuration port is always
// ready; register 0 is full_scale_width and register 1 is timeout_ticks.
module framed_motor_command_receiver #(
  parameter int MOTOR_COUNT = fmcr_pkg::MOTOR_COUNT_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  logic                               operation,
  input  logic [7:0]                         rx_byte,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic                               cause,
  output logic [fmcr_pkg::WIDTH_W-1:0]       width_one,
  output logic [fmcr_pkg::WIDTH_W-1:0]       width_two,
  output logic [fmcr_pkg::WIDTH_W-1:0]       width_three,
  output logic [fmcr_pkg::WIDTH_W-1:0]       width_four,
  output logic [fmcr_pkg::WIDTH_W-1:0]       width_five,
  output logic                               dir_one,
  output logic                               dir_two,
  output logic                               dir_three,
  output logic                               dir_four,
  output logic                               dir_five,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fmcr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fmcr_pkg::CFG_DAT_W-1:0]     cfg_data
);

  localparam int MAXM = fmcr_pkg::MAX_MOTORS;

  logic [fmcr_pkg::WIDTH_W-1:0]   full_scale_width;
  logic [fmcr_pkg::TIMEOUT_W-1:0] timeout_ticks;

  fmcr_pkg::ev_ctrl_t                              ev;
  logic [MOTOR_COUNT-1:0][fmcr_pkg::WORD_W-1:0]    ev_words;

  logic out_advance;
  logic ev_advance;
  logic accept;

  logic [MAXM-1:0][fmcr_pkg::WIDTH_W-1:0] conv_width;
  logic [MAXM-1:0]                        conv_dir;
  logic [MAXM-1:0][fmcr_pkg::WIDTH_W-1:0] result_width;
  logic [MAXM-1:0]                        result_dir;

  // The output register takes a new result whenever it is empty or being
  // drained; the event register moves forward when it is empty or the output
  // register takes its content. Input transactions only wait for the latter.
  assign out_advance = !result_valid || !result_stall;
  assign ev_advance  = !ev.valid || out_advance;
  assign item_stall  = !ev_advance;
  assign accept      = item_valid && ev_advance;

  // Configuration registers. Writes are only expected while the block idles.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale_width <= fmcr_pkg::FULL_SCALE_RESET;
      timeout_ticks    <= fmcr_pkg::TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fmcr_pkg::REG_FULL_SCALE: full_scale_width <= cfg_data[fmcr_pkg::WIDTH_W-1:0];
        fmcr_pkg::REG_TIMEOUT:    timeout_ticks    <= cfg_data[fmcr_pkg::TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  fmcr_parser #(
    .MOTOR_COUNT(MOTOR_COUNT)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .advance      (ev_advance),
    .operation    (operation),
    .rx_byte      (rx_byte),
    .timeout_ticks(timeout_ticks),
    .ev           (ev),
    .ev_words     (ev_words)
  );

  // One converter per configured motor; unused result slots read as zero.
  for (genvar k = 0; k < MAXM; k++) begin : g_motor
    if (k < MOTOR_COUNT) begin : g_used
      fmcr_convert u_convert (
        .word (ev_words[k]),
        .scale(full_scale_width),
        .width(conv_width[k]),
        .dir  (conv_dir[k])
      );
    end else begin : g_unused
      assign conv_width[k] = '0;
      assign conv_dir[k]   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_advance) begin
      result_valid <= ev.valid;
    end
  end

  // A stop result carries all zero widths and directions.
  always_ff @(posedge clk) begin
    if (out_advance && ev.valid) begin
      cause <= ev.cause;
      if (ev.cause == fmcr_pkg::CAUSE_STOP) begin
        result_width <= '0;
        result_dir   <= '0;
      end else begin
        result_width <= conv_width;
        result_dir   <= conv_dir;
      end
    end
  end

  assign width_one   = result_width[0];
  assign width_two   = result_width[1];
  assign width_three = result_width[2];
  assign width_four  = result_width[3];
  assign width_five  = result_width[4];
  assign dir_one     = result_dir[0];
  assign dir_two     = result_dir[1];
  assign dir_three   = result_dir[2];
  assign dir_four    = result_dir[3];
  assign dir_five    = result_dir[4];

endmodule

FILE: rtl/core/fmcr_convert.sv
// Converts one single-precision command into a pulse width and a direction.
module fmcr_convert (
  input  logic [fmcr_pkg::WORD_W-1:0]  word,
  input  logic [fmcr_pkg::WIDTH_W-1:0] scale,
  output logic [fmcr_pkg::WIDTH_W-1:0] width,
  output logic                         dir
);

  logic        sign;
  logic [7:0]  ex;
  logic [22:0] man;
  logic        is_nan;
  logic [23:0] sig;
  logic [35:0] prod;
  logic [3:0]  shamt;

  assign sign   = word[31];
  assign ex     = word[30:23];
  assign man    = word[22:0];
  assign is_nan = (&ex) && (|man);
  assign sig    = {|ex, man};
  assign prod   = 36'(sig) * 36'(scale);
  // Only exponents 115 to 126 leave a nonzero fraction of the scale.
  assign shamt  = 4'(8'd126 - ex);

  always_comb begin
    dir = !sign && ((|ex) || (|man)) && !is_nan;
    if (is_nan) begin
      width = '0;
    end else if (ex >= 8'd127) begin
      width = scale;
    end else if (ex >= 8'd115) begin
      width = fmcr_pkg::WIDTH_W'(prod >> (6'd24 + 6'(shamt)));
    end else begin
      width = '0;
    end
  end

endmodule

FILE: rtl/core/fmcr_parser.sv
// Frame parser and watchdog. Registers one pending result per completed frame or timeout.
module fmcr_parser #(
  parameter int MOTOR_COUNT = fmcr_pkg::MOTOR_COUNT_DEFAULT
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     accept,
  input  logic                                     advance,
  input  logic                                     operation,
  input  logic [7:0]                               rx_byte,
  input  logic [fmcr_pkg::TIMEOUT_W-1:0]           timeout_ticks,
  output fmcr_pkg::ev_ctrl_t                       ev,
  output logic [MOTOR_COUNT-1:0][fmcr_pkg::WORD_W-1:0] ev_words
);

  localparam int PAYLOAD_BYTES = MOTOR_COUNT * 4;
  localparam int IDX_W         = $clog2(PAYLOAD_BYTES);

  localparam logic [2:0] PH_WAIT_S  = 3'd0;
  localparam logic [2:0] PH_WAIT_T  = 3'd1;
  localparam logic [2:0] PH_PAYLOAD = 3'd2;
  localparam logic [2:0] PH_WAIT_E  = 3'd3;
  localparam logic [2:0] PH_WAIT_N  = 3'd4;

  localparam logic [7:0] CHAR_S = 8'h73;
  localparam logic [7:0] CHAR_T = 8'h74;
  localparam logic [7:0] CHAR_E = 8'h65;
  localparam logic [7:0] CHAR_N = 8'h6e;

  logic [2:0]                        phase;
  logic [2:0]                        phase_next;
  logic [IDX_W-1:0]                  byte_index;
  logic [IDX_W-1:0]                  byte_index_next;
  logic                              frame_seen;
  logic                              frame_seen_next;
  logic [fmcr_pkg::IDLE_W-1:0]       idle_ticks;
  logic [fmcr_pkg::IDLE_W-1:0]       idle_ticks_next;
  logic [fmcr_pkg::IDLE_W-1:0]       idle_inc;
  logic [PAYLOAD_BYTES-1:0][7:0]     payload_store;
  logic                              store_we;
  logic                              fire;
  logic                              fire_cause;
  logic                              ev_valid;
  logic                              ev_cause;
  logic [MOTOR_COUNT-1:0][fmcr_pkg::WORD_W-1:0] words;

  assign idle_inc = idle_ticks + fmcr_pkg::IDLE_W'(1);

  always_comb begin
    phase_next      = phase;
    byte_index_next = byte_index;
    frame_seen_next = frame_seen;
    idle_ticks_next = idle_ticks;
    store_we        = 1'b0;
    fire            = 1'b0;
    fire_cause      = fmcr_pkg::CAUSE_FRAME;
    if (operation == fmcr_pkg::OP_TICK) begin
      if (frame_seen) begin
        frame_seen_next = 1'b0;
        idle_ticks_next = '0;
      end else if (idle_inc > fmcr_pkg::IDLE_W'(timeout_ticks)) begin
        idle_ticks_next = '0;
        fire            = 1'b1;
        fire_cause      = fmcr_pkg::CAUSE_STOP;
      end else begin
        idle_ticks_next = idle_inc;
      end
    end else begin
      unique case (phase)
        PH_WAIT_S: begin
          if (rx_byte == CHAR_S) begin
            phase_next = PH_WAIT_T;
          end
          byte_index_next = '0;
        end
        PH_WAIT_T: begin
          if (rx_byte == CHAR_T) begin
            phase_next = PH_PAYLOAD;
          end else begin
            phase_next = (rx_byte == CHAR_S) ? PH_WAIT_T : PH_WAIT_S;
          end
          byte_index_next = '0;
        end
        PH_PAYLOAD: begin
          store_we = 1'b1;
          if (byte_index == IDX_W'(PAYLOAD_BYTES - 1)) begin
            phase_next      = PH_WAIT_E;
            byte_index_next = '0;
          end else begin
            byte_index_next = byte_index + IDX_W'(1);
          end
        end
        PH_WAIT_E: begin
          if (rx_byte == CHAR_E) begin
            phase_next = PH_WAIT_N;
          end else begin
            phase_next = (rx_byte == CHAR_S) ? PH_WAIT_T : PH_WAIT_S;
          end
          byte_index_next = '0;
        end
        PH_WAIT_N: begin
          if (rx_byte == CHAR_N) begin
            phase_next      = PH_WAIT_S;
            frame_seen_next = 1'b1;
            fire            = 1'b1;
          end else begin
            phase_next = (rx_byte == CHAR_S) ? PH_WAIT_T : PH_WAIT_S;
          end
          byte_index_next = '0;
        end
        default: begin
          phase_next      = PH_WAIT_S;
          byte_index_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_WAIT_S;
      byte_index <= '0;
      frame_seen <= 1'b0;
      idle_ticks <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      byte_index <= byte_index_next;
      frame_seen <= frame_seen_next;
      idle_ticks <= idle_ticks_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store_we) begin
      payload_store[byte_index] <= rx_byte;
    end
  end

  // Little-endian assembly of each command word.
  for (genvar k = 0; k < MOTOR_COUNT; k++) begin : g_word
    assign words[k] = {payload_store[4*k+3], payload_store[4*k+2],
                       payload_store[4*k+1], payload_store[4*k]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (advance) begin
      ev_valid <= accept && fire;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && accept && fire) begin
      ev_cause <= fire_cause;
      ev_words <= words;
    end
  end

  assign ev = '{valid: ev_valid, cause: ev_cause};

endmodule
